// ===== hw/rtl/hfas_pkg.sv =====
// ----------------------------------------------------------------------------
// hfas_pkg: shared constants for the half-precision adder/subtractor
// field positions and masks of the binary16 word
// ----------------------------------------------------------------------------
package hfas_pkg;
	localparam int unsigned WordW = 16;
	localparam int unsigned ExpW  = 5;
	localparam int unsigned FracW = 10;
	localparam int unsigned SigW  = FracW + 1;
	localparam logic [WordW-1:0] SignBit  = 16'h8000;
	localparam logic [FracW-1:0] FracMask = 10'h3FF;
	localparam logic FuncAdd = 1'b0;
	localparam logic FuncSub = 1'b1;
endpackage

// ===== hw/rtl/half_float_add_sub.sv =====
// ----------------------------------------------------------------------------
// half_float_add_sub: truncating binary16 adder/subtractor
// aligns, adds, normalizes and packs two half-precision words per request
// ----------------------------------------------------------------------------
// a request passes through the input register, then the result register
// throughput: one request per cycle while the output is not stalled;
// a stalled result holds both stages
// reset clears the valid flags only; data registers are not reset
module half_float_add_sub
	import hfas_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [15:0] x_bits,
	input  logic [15:0] y_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] sum_bits
);
	// stage one: registered request
	logic        valid_s1;
	logic [15:0] x_s1, y_s1;
	// stage two: result register
	logic        valid_s2;
	logic [15:0] sum_s2;

	logic adv_s2, adv_s1;
	// result register takes a new word when empty or being drained
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// negate second operand on subtract, keep 0x0000 positive
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			x_s1 <= x_bits;
			y_s1 <= (func == FuncSub && y_bits != '0) ? (y_bits ^ SignBit) : y_bits;
		end
	end

	// combinational datapath
	logic [ExpW-1:0]  xe, ye, e_big, diff;
	logic signed [SigW:0] xv, yv, a_big, a_small, sh;
	logic signed [SigW+1:0] s;
	logic             neg;
	logic [SigW:0]    mag;
	logic [3:0]       lead;
	logic [FracW-1:0] frac;
	logic [ExpW-1:0]  e_out;
	logic [15:0]      res;
	logic [SigW:0]    norm;

	always_comb begin
		xe = x_s1[14:10];
		ye = y_s1[14:10];
		xv = x_s1[15] ? -$signed({2'b01, x_s1[9:0]}) : $signed({2'b01, x_s1[9:0]});
		yv = y_s1[15] ? -$signed({2'b01, y_s1[9:0]}) : $signed({2'b01, y_s1[9:0]});
		if (xe < ye) begin
			a_big = yv; a_small = xv; e_big = ye; diff = ye - xe;
		end else begin
			a_big = xv; a_small = yv; e_big = xe; diff = xe - ye;
		end
		// arithmetic shift saturates at sign fill for large distances
		sh  = a_small >>> diff;
		s   = {a_big[SigW], a_big} + {sh[SigW], sh};
		neg = s[SigW+1];
		mag = s[SigW:0];
		if (neg) mag = (~s[SigW:0]) + 1'b1;
		// leading-one search over the 12-bit magnitude
		lead = 4'd0;
		for (int i = 0; i <= SigW; i++) begin
			if (mag[i]) lead = 4'(i);
		end
		if (lead == 4'd11) begin
			norm  = mag >> 1;
			e_out = e_big + 5'd1;
		end else begin
			norm  = mag << (4'd10 - lead);
			e_out = e_big - 5'(4'd10 - lead);
		end
		frac = norm[FracW-1:0] & FracMask;
		if (x_s1 == '0) begin
			res = y_s1;
		end else if (y_s1 == '0) begin
			res = x_s1;
		end else if ((x_s1[15] != y_s1[15]) && (x_s1[14:0] == y_s1[14:0])) begin
			res = '0;
		end else if (mag == '0) begin
			res = '0;
		end else begin
			res = {neg, e_out, frac};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			sum_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign sum_bits  = sum_s2;

`ifndef SYNTHESIS
	// stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sum_bits))
		else $error("result changed under stall");
	// a request in stage one reaches the result register once it moves
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("request lost between stages");
	// input is only stalled when both stages are full
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("spurious input stall");
`endif
endmodule
